@@ sv/lgge_pkg.sv @@
// package for the life grid generation engine: sizes, codes, beat structs
// and the state encoding; no dependencies
package lgge_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowCntW = $clog2(MaxRows + 1);
  localparam int ColCntW = $clog2(MaxCols + 1);
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridRows = 2'd0,
    CfgGridCols = 2'd1,
    CfgSpare2   = 2'd2,
    CfgSpare3   = 2'd3
  } lgge_cfg_e;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdStep  = 2'd2,
    CmdNop   = 2'd3
  } lgge_cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StWrite,
    StStep,
    StDone
  } lgge_state_e;

  typedef struct packed {
    lgge_cmd_e  cmd;
    logic [5:0] row_index;
    logic [5:0] column_index;
    logic       cell_in;
  } lgge_in_t;

  typedef struct packed {
    logic cell_out;
    logic step_done;
  } lgge_out_t;

  typedef logic [MaxCols-1:0] lgge_row_t;

endpackage

@@ sv/lgge_row_calc.sv @@
// one generation of one grid row under the b3/s23 rule
// depends on lgge_pkg
module lgge_row_calc (
  input  lgge_pkg::lgge_row_t above_i,
  input  lgge_pkg::lgge_row_t mid_i,
  input  lgge_pkg::lgge_row_t below_i,
  input  lgge_pkg::lgge_row_t col_mask_i,
  output lgge_pkg::lgge_row_t row_o
);
  import lgge_pkg::*;

  always_comb begin
    logic [MaxCols+1:0] pa;
    logic [MaxCols+1:0] pm;
    logic [MaxCols+1:0] pb;
    logic [3:0]         n;
    lgge_row_t          nxt;
    // columns outside the grid read as dead neighbours
    pa  = {1'b0, above_i & col_mask_i, 1'b0};
    pm  = {1'b0, mid_i & col_mask_i, 1'b0};
    pb  = {1'b0, below_i & col_mask_i, 1'b0};
    nxt = '0;
    for (int c = 0; c < MaxCols; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2]) + 4'(pm[c]) + 4'(pm[c+2])
        + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      nxt[c] = pm[c+1] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
    end
    // columns outside the grid keep their old value
    row_o = (nxt & col_mask_i) | (mid_i & ~col_mask_i);
  end

endmodule

@@ sv/life_grid_generation_engine.sv @@
// life grid top level: grid memory (one row word per entry), command
// sequencer, output register; depends on lgge_pkg and lgge_row_calc
//
// a read or write inside the grid passes through its read or write state to
// the done state; one outside it, the unused command and a step with zero
// rows go straight to the done state; a step sweeps the rows in use (one row
// word per cycle through the single grid memory, read and write port)
// one command in flight; the next beat is taken only back in the idle state,
// after the result beat is loaded; a result beat left waiting holds the
// sequencer in its done state; a new beat is taken while a result waits
// reset sets the size registers to 64 and clears the per-row valid bits, so the
// grid reads as all dead at once; no clearing pass
module life_grid_generation_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lgge_pkg::lgge_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lgge_pkg::lgge_out_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lgge_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lgge_pkg::CfgW-1:0]    cfg_wdata_i
);
  import lgge_pkg::*;

  // configuration
  logic [CfgW-1:0] grid_rows_q;
  logic [CfgW-1:0] grid_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CfgW'(64);
      grid_cols_q <= CfgW'(64);
    end else if (cfg_we_i) begin
      case (lgge_cfg_e'(cfg_index_i))
        CfgGridRows: grid_rows_q <= cfg_wdata_i;
        CfgGridCols: grid_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // size in use, clamped to the memory
  logic [RowCntW-1:0] nr;
  logic [ColCntW-1:0] nc;
  lgge_row_t          col_mask;

  assign nr = (32'(grid_rows_q) > MaxRows) ? RowCntW'(MaxRows) : RowCntW'(grid_rows_q);
  assign nc = (32'(grid_cols_q) > MaxCols) ? ColCntW'(MaxCols) : ColCntW'(grid_cols_q);

  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      col_mask[c] = (32'(c) < 32'(nc));
    end
  end

  // grid memory: one row word per entry, valid bits make unwritten rows dead
  lgge_row_t            grid_mem [MaxRows];
  logic [MaxRows-1:0]   row_vld_q;
  logic                 rd_en;
  logic [RowW-1:0]      rd_addr;
  lgge_row_t            rdata_q;
  logic                 rvld_q;
  logic                 we;
  logic [RowW-1:0]      waddr;
  lgge_row_t            wdata;
  lgge_row_t            row_rd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      grid_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= row_vld_q[rd_addr];
      end
    end
  end

  assign row_rd = rvld_q ? rdata_q : '0;

  // sequencer state
  lgge_state_e        state_q, state_d;
  logic [RowCntW-1:0] cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;
  lgge_out_t          out_q, out_d;
  lgge_out_t          res_q, res_d;
  lgge_in_t           item_q;
  lgge_row_t          above_q, above_d;
  lgge_row_t          mid_q, mid_d;
  lgge_row_t          below;
  lgge_row_t          new_row;
  logic               in_beat;
  logic               slot_free;
  logic               in_grid;
  logic [ColW-1:0]    col_sel;

  assign in_ready_o = (state_q == StIdle);
  assign in_beat    = in_valid_i && in_ready_o;
  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_grid    = (32'(in_data_i.row_index) < 32'(nr))
                   && (32'(in_data_i.column_index) < 32'(nc));
  assign col_sel    = ColW'(item_q.column_index);

  // in a step the row under the window is below the middle row; past the
  // last row in use it is dead
  assign below = (cnt_q < nr) ? row_rd : '0;

  lgge_row_calc u_row_calc (
    .above_i    (above_q),
    .mid_i      (mid_q),
    .below_i    (below),
    .col_mask_i (col_mask),
    .row_o      (new_row)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    res_d     = res_q;
    above_d   = above_q;
    mid_d     = mid_q;
    rd_en     = 1'b0;
    rd_addr   = RowW'(in_data_i.row_index);
    we        = 1'b0;
    waddr     = RowW'(item_q.row_index);
    wdata     = (row_rd & ~(lgge_row_t'(1) << col_sel))
              | (lgge_row_t'(item_q.cell_in) << col_sel);

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_beat) begin
          res_d = '0;
          case (in_data_i.cmd)
            CmdWrite: begin
              rd_en   = in_grid;
              state_d = in_grid ? StWrite : StDone;
            end
            CmdRead: begin
              rd_en   = in_grid;
              state_d = in_grid ? StRead : StDone;
            end
            CmdStep: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              cnt_d   = '0;
              above_d = '0;
              mid_d   = '0;
              res_d.step_done = 1'b1;
              state_d = (nr == '0) ? StDone : StStep;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StRead: begin
        res_d.cell_out = row_rd[col_sel];
        state_d        = StDone;
      end
      StWrite: begin
        // read-modify-write of the addressed row word
        we      = 1'b1;
        state_d = StDone;
      end
      StStep: begin
        // window above/mid/below slides down one row per cycle; new middle
        // row goes back in place, its old value is already in the window
        we      = (cnt_q != '0);
        waddr   = RowW'(cnt_q - RowCntW'(1));
        wdata   = new_row;
        rd_en   = 1'b1;
        rd_addr = RowW'(cnt_q + RowCntW'(1));
        above_d = mid_q;
        mid_d   = below;
        cnt_d   = cnt_q + RowCntW'(1);
        if (cnt_q == nr) begin
          rd_en   = 1'b0;
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    res_q   <= res_d;
    above_q <= above_d;
    mid_q   <= mid_d;
    if (in_beat) begin
      item_q <= in_data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // memory is written only by a command in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == StWrite || state_q == StStep))
    else $error("grid write outside write or step");

  // a new result beat is loaded only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_d && !(out_vld_q && !out_ready_i) && state_q != StDone) |-> !out_vld_d || out_vld_q)
    else $error("result beat loaded outside done state");

  // step sweep never runs past the rows in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStep) |-> (cnt_q <= nr))
    else $error("step row counter past grid size");

  // a result beat never reports a cell and a finished step at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.cell_out && out_q.step_done))
    else $error("result beat with both cell and step flags");

  // write and read in a step never hit the same row word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("grid read and write collide");

endmodule

@@ sim/tb_life_grid_generation_engine.sv @@
// self-checking testbench for life_grid_generation_engine: directed table plus
// random commands over several grid sizes, checked against a b3/s23 grid model
// depends on lgge_pkg and the engine rtl only
`timescale 1ns / 100ps

module tb_life_grid_generation_engine;
  import lgge_pkg::*;

  localparam real ClkPeriod   = 2.0;
  localparam int  RandomBeats = 450;
  localparam int  StallLimit  = 1000;     // cycles with no beat moving on either side
  localparam int  TailCycles  = MaxRows + 8;
  localparam int  NumSizes    = 10;

  // one row of the directed table; want only counts when typed is set
  typedef struct packed {
    lgge_in_t  beat;
    logic      typed;
    lgge_out_t want;
  } directed_row_t;

  localparam lgge_out_t Quiet    = '0;
  localparam lgge_out_t StepDone = '{cell_out: 1'b0, step_done: 1'b1};
  localparam int        NumDirected = 22;

  // top row blinker against the upper edge, a lone corner cell, a cell in the
  // last column that would touch the first one under wrap-around
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{'{CmdRead,  6'd0,  6'd0,  1'b0}, 1'b1, Quiet},     // grid clear after reset
    '{'{CmdRead,  6'd63, 6'd63, 1'b0}, 1'b1, Quiet},
    '{'{CmdWrite, 6'd63, 6'd63, 1'b1}, 1'b1, Quiet},
    '{'{CmdRead,  6'd63, 6'd63, 1'b0}, 1'b0, Quiet},
    '{'{CmdWrite, 6'd0,  6'd0,  1'b1}, 1'b1, Quiet},
    '{'{CmdWrite, 6'd0,  6'd1,  1'b1}, 1'b1, Quiet},
    '{'{CmdWrite, 6'd0,  6'd2,  1'b1}, 1'b1, Quiet},
    '{'{CmdWrite, 6'd0,  6'd63, 1'b1}, 1'b1, Quiet},
    '{'{CmdStep,  6'd0,  6'd0,  1'b0}, 1'b1, StepDone},
    '{'{CmdRead,  6'd0,  6'd1,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd1,  6'd1,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd0,  6'd0,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd63, 6'd63, 1'b0}, 1'b0, Quiet},
    '{'{CmdNop,   6'd63, 6'd63, 1'b1}, 1'b1, Quiet},     // unused opcode does nothing
    '{'{CmdWrite, 6'd1,  6'd1,  1'b0}, 1'b1, Quiet},
    '{'{CmdStep,  6'd0,  6'd0,  1'b0}, 1'b1, StepDone},
    '{'{CmdRead,  6'd0,  6'd1,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd0,  6'd0,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd1,  6'd0,  1'b0}, 1'b0, Quiet},
    '{'{CmdRead,  6'd0,  6'd63, 1'b0}, 1'b0, Quiet},
    '{'{CmdStep,  6'd0,  6'd0,  1'b0}, 1'b1, StepDone},
    '{'{CmdRead,  6'd0,  6'd1,  1'b0}, 1'b0, Quiet}
  };

  // grid sizes walked by the random part: zero, one, above the maximum, full
  localparam logic [CfgW-1:0] SizeRows [NumSizes] =
    '{7'd3, 7'd1, 7'd0, 7'd127, 7'd6, 7'd5, 7'd2, 7'd64, 7'd64, 7'd10};
  localparam logic [CfgW-1:0] SizeCols [NumSizes] =
    '{7'd3, 7'd1, 7'd9, 7'd127, 7'd0, 7'd12, 7'd64, 7'd1, 7'd64, 7'd7};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  lgge_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  lgge_out_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  // model of the grid and its size registers
  bit [MaxCols-1:0] life_grid [MaxRows];
  bit [CfgW-1:0]    rows_cfg = 7'd64;
  bit [CfgW-1:0]    cols_cfg = 7'd64;

  lgge_out_t expected_cells [$];
  bit        failed      = 1'b0;
  bit        sender_idle = 1'b0;   // random gaps between input beats
  bit        stall_mode  = 1'b0;   // random back-pressure on results
  int        quiet_cycles = 0;

  life_grid_generation_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // sizes clamp to the physical grid
  function automatic int active_rows();
    return (rows_cfg < MaxRows) ? int'(rows_cfg) : MaxRows;
  endfunction

  function automatic int active_cols();
    return (cols_cfg < MaxCols) ? int'(cols_cfg) : MaxCols;
  endfunction

  // one b3/s23 generation over the cells in use; everything outside the
  // size is a dead neighbour and keeps its old value
  function automatic void advance_life(int nr, int nc);
    bit [MaxCols-1:0] old_grid [MaxRows];
    int live;
    int rr;
    int cc;
    old_grid = life_grid;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
              live += old_grid[rr][cc];
          end
        end
        life_grid[r][c] = old_grid[r][c] ? (live == 2 || live == 3) : (live == 3);
      end
    end
  endfunction

  // applies one accepted command to the model and returns its result beat
  function automatic lgge_out_t apply_command(lgge_in_t beat);
    lgge_out_t res;
    int        nr;
    int        nc;
    bit        hit;
    res = '0;
    nr  = active_rows();
    nc  = active_cols();
    hit = (int'(beat.row_index) < nr) && (int'(beat.column_index) < nc);
    case (beat.cmd)
      CmdWrite: begin
        if (hit) life_grid[beat.row_index][beat.column_index] = beat.cell_in;
      end
      CmdRead: begin
        if (hit) res.cell_out = life_grid[beat.row_index][beat.column_index];
      end
      CmdStep: begin
        advance_life(nr, nc);
        res.step_done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // random command: mostly inside the size, often at its far corner
  function automatic lgge_in_t draw_command();
    lgge_in_t beat;
    int       pick;
    int       nr;
    int       nc;
    nr   = active_rows();
    nc   = active_cols();
    pick = $urandom_range(0, 99);
    beat.cmd = (pick < 40) ? CmdWrite : (pick < 80) ? CmdRead :
               (pick < 95) ? CmdStep  : CmdNop;
    if (nr > 0 && nc > 0 && $urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 1) != 0) begin
        beat.row_index    = 6'(nr - 1 - $urandom_range(0, (nr > 4) ? 3 : nr - 1));
        beat.column_index = 6'(nc - 1 - $urandom_range(0, (nc > 4) ? 3 : nc - 1));
      end else begin
        beat.row_index    = 6'($urandom_range(0, nr - 1));
        beat.column_index = 6'($urandom_range(0, nc - 1));
      end
    end else begin
      beat.row_index    = 6'($urandom);
      beat.column_index = 6'($urandom);
    end
    beat.cell_in = ($urandom_range(0, 2) != 0);
    return beat;
  endfunction

  // gap before a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    if (!sender_idle || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  // drives one command beat and waits for it to be taken; valid stays high
  // on return so a back-to-back beat can follow in the same step
  task automatic send_command(input lgge_in_t beat, input bit typed, input lgge_out_t want);
    lgge_out_t predicted;
    int        gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_command(beat);
    expected_cells.push_back(typed ? want : predicted);
  endtask

  // holds the sender off until every result beat has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size_reg(input lgge_cfg_e idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgGridRows: rows_cfg = value;
      CfgGridCols: cols_cfg = value;
      default: ;   // spare indexes are ignored by the block
    endcase
  endtask

  // result checker and back-pressure; values are read right after the edge,
  // before any register of this step has updated
  always @(posedge clk_i) begin : result_check
    lgge_out_t want;
    int        stall_left;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cells.size() == 0) begin
        $error("result beat with no command outstanding: %b", out_data_o);
        failed = 1'b1;
      end else begin
        want = expected_cells.pop_front();
        if (out_data_o.cell_out !== want.cell_out) begin
          $error("cell_out: expected %0b, got %0b", want.cell_out, out_data_o.cell_out);
          failed = 1'b1;
        end
        if (out_data_o.step_done !== want.step_done) begin
          $error("step_done: expected %0b, got %0b", want.step_done, out_data_o.step_done);
          failed = 1'b1;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (stall_mode && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                   $urandom_range(1, 3);
    end
  end

  // watchdog: a run where no beat moves for too long is a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("life_grid_generation_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset size of 64 x 64
    for (int i = 0; i < NumDirected; i++)
      send_command(DirectedRows[i].beat, DirectedRows[i].typed, DirectedRows[i].want);

    // random commands, one grid size after another
    for (int s = 0; s < NumSizes; s++) begin
      wait_results_drained();
      write_size_reg(CfgGridRows, SizeRows[s]);
      write_size_reg(CfgGridCols, SizeCols[s]);
      if (s == 3) begin
        write_size_reg(CfgSpare2, 7'h7F);
        write_size_reg(CfgSpare3, 7'(
          $urandom));
      end
      for (int n = 0; n < RandomBeats / NumSizes; n++) begin
        if (n % 15 == 0) begin
          sender_idle = ($urandom_range(0, 2) != 0);
          stall_mode  = ($urandom_range(0, 2) != 0);
        end
        if ($urandom_range(0, 39) == 0) wait_results_drained();
        send_command(draw_command(), 1'b0, Quiet);
      end
    end

    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (!failed) begin
      $display("life_grid_generation_engine test passed");
    end else begin
      $display("life_grid_generation_engine test failed");
    end
    $finish;
  end

endmodule
